// ===== rtl/core/avcc_pkg.sv =====
`default_nettype none

package avcc_pkg;

  localparam logic [7:0] VERSION_ONE   = 8'h01;
  localparam logic [7:0] LENSIZE_RSVD  = 8'hFC;
  localparam logic [7:0] SPSCOUNT_RSVD = 8'hE0;
  localparam logic [7:0] SPSCOUNT_MASK = 8'h1F;
  localparam logic [7:0] LENSIZE_MASK  = 8'h03;

  typedef enum logic [14:0] {
    PH_VERSION   = 15'h0001,
    PH_PROFILE   = 15'h0002,
    PH_COMPAT    = 15'h0004,
    PH_LEVEL     = 15'h0008,
    PH_LENSIZE   = 15'h0010,
    PH_SPSCOUNT  = 15'h0020,
    PH_SPSLEN_HI = 15'h0040,
    PH_SPSLEN_LO = 15'h0080,
    PH_SPSDATA   = 15'h0100,
    PH_PPSCOUNT  = 15'h0200,
    PH_PPSLEN_HI = 15'h0400,
    PH_PPSLEN_LO = 15'h0800,
    PH_PPSDATA   = 15'h1000,
    PH_TRAILING  = 15'h2000,
    PH_FAILED    = 15'h4000
  } phase_t;

  typedef enum logic [3:0] {
    KIND_VERSION   = 4'd0,
    KIND_PROFILE   = 4'd1,
    KIND_COMPAT    = 4'd2,
    KIND_LEVEL     = 4'd3,
    KIND_LENSIZE   = 4'd4,
    KIND_SPSCOUNT  = 4'd5,
    KIND_SPSLEN_HI = 4'd6,
    KIND_SPSLEN_LO = 4'd7,
    KIND_SPSDATA   = 4'd8,
    KIND_PPSCOUNT  = 4'd9,
    KIND_PPSLEN_HI = 4'd10,
    KIND_PPSLEN_LO = 4'd11,
    KIND_PPSDATA   = 4'd12,
    KIND_TRAILING  = 4'd13,
    KIND_FAILED    = 4'd14
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_VERSION  = 3'd1,
    ERR_LENSIZE  = 3'd2,
    ERR_SPSCOUNT = 3'd3,
    ERR_TRUNC    = 3'd4
  } err_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  sets_remaining;
    logic [7:0]  current_set;
    logic [15:0] payload_remaining;
    logic [7:0]  length_high_byte;
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
    logic       buffer_end;
  } item_t;

  typedef struct packed {
    kind_t      byte_kind;
    logic [7:0] field_value;
    logic [7:0] set_index;
    logic       set_last_byte;
    err_t       error_code;
    logic       record_done;
  } result_t;

  function automatic kind_t phase_kind(input phase_t p);
    kind_t k;
    case (p)
      PH_VERSION:   k = KIND_VERSION;
      PH_PROFILE:   k = KIND_PROFILE;
      PH_COMPAT:    k = KIND_COMPAT;
      PH_LEVEL:     k = KIND_LEVEL;
      PH_LENSIZE:   k = KIND_LENSIZE;
      PH_SPSCOUNT:  k = KIND_SPSCOUNT;
      PH_SPSLEN_HI: k = KIND_SPSLEN_HI;
      PH_SPSLEN_LO: k = KIND_SPSLEN_LO;
      PH_SPSDATA:   k = KIND_SPSDATA;
      PH_PPSCOUNT:  k = KIND_PPSCOUNT;
      PH_PPSLEN_HI: k = KIND_PPSLEN_HI;
      PH_PPSLEN_LO: k = KIND_PPSLEN_LO;
      PH_PPSDATA:   k = KIND_PPSDATA;
      PH_TRAILING:  k = KIND_TRAILING;
      default:      k = KIND_FAILED;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/avcc_in_if.sv =====
`default_nettype none

interface avcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;
  logic       buffer_end;

  modport source (output valid, output data_byte, output record_start, output buffer_end,
                  input ready);
  modport sink (input valid, input data_byte, input record_start, input buffer_end,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/avcc_out_if.sv =====
`default_nettype none

interface avcc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] byte_kind;
  logic [7:0] field_value;
  logic [7:0] set_index;
  logic       set_last_byte;
  logic [2:0] error_code;
  logic       record_done;

  modport source (output valid, output byte_kind, output field_value, output set_index,
                  output set_last_byte, output error_code, output record_done,
                  input ready);
  modport sink (input valid, input byte_kind, input field_value, input set_index,
                input set_last_byte, input error_code, input record_done,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/avcc_step.sv =====
`default_nettype none

module avcc_step (
  input  avcc_pkg::item_t   item,
  input  avcc_pkg::state_t  state,
  output avcc_pkg::state_t  state_next,
  output avcc_pkg::result_t res
);

  avcc_pkg::state_t cur;
  logic [7:0]       b;
  logic [7:0]       fin_sets;
  logic [7:0]       fin_cur;
  logic [15:0]      len_full;
  logic [15:0]      pay_dec;
  logic [7:0]       sps_count;

  always_comb begin
    b = item.data_byte;
    // restart from the version byte with cleared counters
    if (item.record_start) begin
      cur.phase             = avcc_pkg::PH_VERSION;
      cur.sets_remaining    = 8'd0;
      cur.current_set       = 8'd0;
      cur.payload_remaining = 16'd0;
      cur.length_high_byte  = 8'd0;
    end else begin
      cur = state;
    end

    fin_sets  = cur.sets_remaining - 8'd1;
    fin_cur   = cur.current_set + 8'd1;
    len_full  = {cur.length_high_byte, b};
    pay_dec   = cur.payload_remaining - 16'd1;
    sps_count = b & avcc_pkg::SPSCOUNT_MASK;

    state_next        = cur;
    res.byte_kind     = avcc_pkg::phase_kind(cur.phase);
    res.field_value   = b;
    res.set_index     = 8'd0;
    res.set_last_byte = 1'b0;
    res.error_code    = avcc_pkg::ERR_NONE;
    res.record_done   = 1'b0;

    case (cur.phase)
      avcc_pkg::PH_VERSION: begin
        if (b != avcc_pkg::VERSION_ONE) begin
          res.error_code = avcc_pkg::ERR_VERSION;
        end else begin
          state_next.phase = avcc_pkg::PH_PROFILE;
        end
      end
      avcc_pkg::PH_PROFILE: state_next.phase = avcc_pkg::PH_COMPAT;
      avcc_pkg::PH_COMPAT:  state_next.phase = avcc_pkg::PH_LEVEL;
      avcc_pkg::PH_LEVEL:   state_next.phase = avcc_pkg::PH_LENSIZE;
      avcc_pkg::PH_LENSIZE: begin
        res.field_value = b & avcc_pkg::LENSIZE_MASK;
        if ((b & avcc_pkg::LENSIZE_RSVD) != avcc_pkg::LENSIZE_RSVD) begin
          res.error_code = avcc_pkg::ERR_LENSIZE;
        end else begin
          state_next.phase = avcc_pkg::PH_SPSCOUNT;
        end
      end
      avcc_pkg::PH_SPSCOUNT: begin
        res.field_value = sps_count;
        if ((b & avcc_pkg::SPSCOUNT_RSVD) != avcc_pkg::SPSCOUNT_RSVD) begin
          res.error_code = avcc_pkg::ERR_SPSCOUNT;
        end else begin
          state_next.sets_remaining = sps_count;
          state_next.current_set    = 8'd0;
          state_next.phase = (sps_count != 8'd0) ? avcc_pkg::PH_SPSLEN_HI
                                                 : avcc_pkg::PH_PPSCOUNT;
        end
      end
      avcc_pkg::PH_PPSCOUNT: begin
        state_next.sets_remaining = b;
        state_next.current_set    = 8'd0;
        if (b != 8'd0) begin
          state_next.phase = avcc_pkg::PH_PPSLEN_HI;
        end else begin
          state_next.phase = avcc_pkg::PH_TRAILING;
          res.record_done  = 1'b1;
        end
      end
      avcc_pkg::PH_SPSLEN_HI, avcc_pkg::PH_PPSLEN_HI: begin
        res.set_index               = cur.current_set;
        state_next.length_high_byte = b;
        state_next.phase = (cur.phase == avcc_pkg::PH_SPSLEN_HI) ? avcc_pkg::PH_SPSLEN_LO
                                                                 : avcc_pkg::PH_PPSLEN_LO;
      end
      avcc_pkg::PH_SPSLEN_LO, avcc_pkg::PH_PPSLEN_LO,
      avcc_pkg::PH_SPSDATA, avcc_pkg::PH_PPSDATA: begin
        res.set_index = cur.current_set;
        if (cur.phase == avcc_pkg::PH_SPSLEN_LO || cur.phase == avcc_pkg::PH_PPSLEN_LO) begin
          state_next.payload_remaining = len_full;
        end else begin
          state_next.payload_remaining = pay_dec;
          res.set_last_byte            = (pay_dec == 16'd0);
        end
        if (state_next.payload_remaining == 16'd0) begin
          // set finished: advance to the next set, the next list or the trailing bytes
          state_next.current_set    = fin_cur;
          state_next.sets_remaining = fin_sets;
          if (cur.phase == avcc_pkg::PH_SPSLEN_LO || cur.phase == avcc_pkg::PH_SPSDATA) begin
            state_next.phase = (fin_sets != 8'd0) ? avcc_pkg::PH_SPSLEN_HI
                                                  : avcc_pkg::PH_PPSCOUNT;
          end else if (fin_sets != 8'd0) begin
            state_next.phase = avcc_pkg::PH_PPSLEN_HI;
          end else begin
            state_next.phase = avcc_pkg::PH_TRAILING;
            res.record_done  = 1'b1;
          end
        end else begin
          case (cur.phase)
            avcc_pkg::PH_SPSLEN_LO: state_next.phase = avcc_pkg::PH_SPSDATA;
            avcc_pkg::PH_PPSLEN_LO: state_next.phase = avcc_pkg::PH_PPSDATA;
            default:                state_next.phase = cur.phase;
          endcase
        end
      end
      default: begin
        // trailing and failed bytes pass through untouched
      end
    endcase

    if (res.error_code != avcc_pkg::ERR_NONE) begin
      state_next.phase = avcc_pkg::PH_FAILED;
    end else if (item.buffer_end && !res.record_done &&
                 cur.phase != avcc_pkg::PH_TRAILING && cur.phase != avcc_pkg::PH_FAILED) begin
      res.error_code   = avcc_pkg::ERR_TRUNC;
      state_next.phase = avcc_pkg::PH_FAILED;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/avcc_out_reg.sv =====
`default_nettype none

module avcc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  avcc_pkg::result_t res,
  output logic              can_load,
  avcc_out_if.source        out_ch
);

  logic              valid;
  avcc_pkg::result_t data;

  assign can_load = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign out_ch.valid         = valid;
  assign out_ch.byte_kind     = data.byte_kind;
  assign out_ch.field_value   = data.field_value;
  assign out_ch.set_index     = data.set_index;
  assign out_ch.set_last_byte = data.set_last_byte;
  assign out_ch.error_code    = data.error_code;
  assign out_ch.record_done   = data.record_done;

endmodule

`default_nettype wire

// ===== rtl/core/avcc_record_parser_top.sv =====
`default_nettype none

// Tags an AVC decoder configuration record one byte per transfer. Each input byte
// yields exactly one result, registered in the cycle after its transfer; a new byte is
// taken every cycle as long as the result register is empty or being drained, since
// the next parser state (phase, set counters, payload length) is computed combinationally.
// The input stalls only while a result waits untaken. record_start on a byte restarts
// the parser at the version byte; after an error every byte is tagged as failed until
// the next record_start.
module avcc_record_parser_top (
  input  logic       clk,
  input  logic       rst,
  avcc_in_if.sink    in_ch,
  avcc_out_if.source out_ch
);

  avcc_pkg::state_t  state;
  avcc_pkg::state_t  state_next;
  avcc_pkg::item_t   item;
  avcc_pkg::result_t step_res;
  logic              can_load;
  logic              in_fire;

  assign item.data_byte    = in_ch.data_byte;
  assign item.record_start = in_ch.record_start;
  assign item.buffer_end   = in_ch.buffer_end;

  assign in_ch.ready = can_load;
  assign in_fire     = in_ch.valid && can_load;

  avcc_step u_step (
    .item       (item),
    .state      (state),
    .state_next (state_next),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase             <= avcc_pkg::PH_VERSION;
      state.sets_remaining    <= 8'd0;
      state.current_set       <= 8'd0;
      state.payload_remaining <= 16'd0;
      state.length_high_byte  <= 8'd0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  avcc_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (in_fire),
    .res      (step_res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  a_err_fails: assert property (@(posedge clk) disable iff (rst)
    in_fire && step_res.error_code != avcc_pkg::ERR_NONE |=> state.phase == avcc_pkg::PH_FAILED)
    else $error("error byte did not move parser to failed phase");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.record_done |-> out_ch.error_code == avcc_pkg::ERR_NONE)
    else $error("record completion flagged together with an error");

  a_last_on_data: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.set_last_byte |->
      out_ch.byte_kind == avcc_pkg::KIND_SPSDATA || out_ch.byte_kind == avcc_pkg::KIND_PPSDATA)
    else $error("set_last_byte on a non-payload byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled while result register free");

endmodule

`default_nettype wire
